// File: hw/rtl/rrts_pkg.sv
// Shared types, codes and helper functions of the round-robin task scheduler.
package rrts_pkg;

  localparam int DEF_TASK_SLOTS = 16;
  localparam int SLOT_W = 4;
  localparam int OP_W = 3;
  localparam int KIND_W = 3;
  localparam int RCOUNT_W = 5;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_START   = 3'd0,
    OP_EXPIRY  = 3'd1,
    OP_BLOCK   = 3'd2,
    OP_UNBLOCK = 3'd3,
    OP_YIELD   = 3'd4,
    OP_EXIT    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_RUNNING = 3'd0,
    ST_READY   = 3'd1,
    ST_BLOCKED = 3'd2,
    ST_WAITING = 3'd3,
    ST_HANGING = 3'd4,
    ST_OVER    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_STATUS = 2'd1,
    ERR_KIND   = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_SCHED
  } seq_t;

  typedef enum logic [2:0] {
    Q_HOLD,
    Q_WRITE_AT,
    Q_SHIFT_RIGHT,
    Q_SHIFT_LEFT,
    Q_REMOVE
  } qop_t;

  typedef struct packed {
    qop_t op;
    logic ins;
  } qcmd_t;

  typedef struct packed {
    logic    en0;
    status_t val0;
    logic    en1;
    status_t val1;
  } swr_t;

  function automatic logic is_blocked(status_t s);
    return (s == ST_BLOCKED) || (s == ST_WAITING) || (s == ST_HANGING);
  endfunction

  function automatic logic kind_ok(logic [KIND_W-1:0] k);
    return (k >= KIND_W'(ST_BLOCKED)) && (k <= KIND_W'(ST_HANGING));
  endfunction

endpackage

// File: hw/rtl/rrts_queue_cell.sv
// One entry of the ready queue chain; shifts, inserts and compacts with its neighbors.
module rrts_queue_cell import rrts_pkg::*; #(
  parameter int IDX = 0,
  parameter int SW = 4,
  parameter int CW = 5
) (
  input  logic          clk,
  input  qcmd_t         cmd,
  input  logic [SW-1:0] value,
  input  logic [SW-1:0] key,
  input  logic [SW-1:0] pos,
  input  logic [CW-1:0] count,
  input  logic [SW-1:0] left,
  input  logic [SW-1:0] right,
  input  logic          hit_in,
  output logic          hit_out,
  output logic [SW-1:0] entry
);

  logic [SW-1:0] data;
  logic [SW-1:0] data_next;
  logic          valid;
  logic          here;

  assign valid   = CW'(IDX) < count;
  assign here    = SW'(IDX) == pos;
  assign hit_out = hit_in | (valid && (data == key));
  assign entry   = data;

  always_comb begin
    unique case (cmd.op)
      Q_HOLD:        data_next = data;
      Q_WRITE_AT:    data_next = here ? value : data;
      Q_SHIFT_RIGHT: data_next = left;
      Q_SHIFT_LEFT:  data_next = (cmd.ins && here) ? value : right;
      Q_REMOVE:      data_next = hit_out ? right : data;
      default:       data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// File: hw/rtl/rrts_slot_cell.sv
// Status register of one task slot with two prioritized write ports.
module rrts_slot_cell import rrts_pkg::*; #(
  parameter int IDX = 0,
  parameter int SW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  swr_t          wr,
  input  logic [SW-1:0] addr0,
  input  logic [SW-1:0] addr1,
  output status_t       status
);

  localparam status_t RST_STATUS = (IDX == 0) ? ST_RUNNING : ST_OVER;

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= RST_STATUS;
    end else if (wr.en1 && (addr1 == SW'(IDX))) begin
      status <= wr.val1;
    end else if (wr.en0 && (addr0 == SW'(IDX))) begin
      status <= wr.val0;
    end
  end

endmodule

// File: hw/rtl/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler: event sequencer, slot row and queue chain.
// An event is accepted in the idle state and run in the exec state; its result is registered once
// the output is free, for an exit with reschedule only after a further schedule step.
// The sequencer holds one event at a time and accepts the next only after the result is loaded.
// Reset (rst, synchronous): slot 0 running, all other slots over, queue empty, idle slot 1.
module round_robin_task_scheduler import rrts_pkg::*; #(
  parameter int TASK_SLOTS = DEF_TASK_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [SLOT_W-1:0]     cfg_wr_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // Fields from bit 0: op, task_slot, block_kind, reschedule.
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // Fields from bit 0: running_task, previous_task, switched, ready_count, error_code.
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int SW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int XW = (SW > SLOT_W) ? SW : SLOT_W;
  localparam int RW = (CW > RCOUNT_W) ? CW : RCOUNT_W;

  seq_t                seq, seq_next;
  logic [OP_W-1:0]     op_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [KIND_W-1:0]   kind_r;
  logic                ns_r;
  logic [SLOT_W-1:0]   idle_slot;
  logic [SW-1:0]       cur;
  logic [CW-1:0]       count;

  status_t             stat [TASK_SLOTS];
  logic [SW-1:0]       entries [TASK_SLOTS];
  logic                hits [TASK_SLOTS+1];

  logic [XW-1:0]       slot_x, idle_x;
  logic [SW-1:0]       slot_i, idle_i;
  logic                slot_ok, idle_ok, full, empty, found;
  status_t             st_slot, st_cur, st_idle, kind_s;
  op_t                 eop;

  err_t                err;
  qcmd_t               q_cmd, q_cmd_g;
  logic [SW-1:0]       q_value, q_pos;
  logic [CW-1:0]       count_next, cnt_after;
  logic [SW-1:0]       cur_next, next_task;
  swr_t                swr, swr_g;
  logic [SW-1:0]       addr0, addr1;
  logic                sw, to_sched, do_sched, a, a_x, sched_bad;
  status_t             idle_eff;

  logic                out_free, go, commit, load;
  logic [SW-1:0]       run_o;
  logic [CW-1:0]       cnt_o;
  logic [XW-1:0]       run_x, prev_x;
  logic [RW-1:0]       cnt_x;

  assign slot_x  = XW'(slot_r);
  assign idle_x  = XW'(idle_slot);
  assign slot_i  = slot_x[SW-1:0];
  assign idle_i  = idle_x[SW-1:0];
  assign slot_ok = int'(slot_x) < TASK_SLOTS;
  assign idle_ok = int'(idle_x) < TASK_SLOTS;
  assign full    = int'(count) >= TASK_SLOTS;
  assign empty   = count == '0;
  assign st_slot = stat[slot_i];
  assign st_cur  = stat[cur];
  assign st_idle = stat[idle_i];
  assign kind_s  = status_t'(kind_r);
  assign found   = hits[TASK_SLOTS];
  assign eop     = (seq == SQ_SCHED) ? OP_EXPIRY : op_t'(op_r);

  assign out_free = !m_tvalid || m_tready;
  assign go       = ((seq == SQ_EXEC) || (seq == SQ_SCHED)) && out_free;
  assign commit   = go && (err == ERR_OK);
  assign load     = go && !to_sched;

  always_comb begin
    err        = ERR_OK;
    q_cmd      = '{op: Q_HOLD, ins: 1'b0};
    q_value    = '0;
    q_pos      = '0;
    count_next = count;
    cur_next   = cur;
    swr        = '{en0: 1'b0, val0: ST_READY, en1: 1'b0, val1: ST_RUNNING};
    addr0      = '0;
    addr1      = '0;
    sw         = 1'b0;
    to_sched   = 1'b0;
    do_sched   = 1'b0;
    a          = 1'b0;
    idle_eff   = st_idle;
    sched_bad  = 1'b0;
    next_task  = cur;
    cnt_after  = count - CW'(found);
    a_x        = (slot_i != cur) && (st_cur == ST_RUNNING);

    unique case (eop)
      OP_START: begin
        if (!slot_ok || (st_slot != ST_OVER) || full) begin
          err = ERR_STATUS;
        end else begin
          q_cmd.op   = Q_WRITE_AT;
          q_value    = slot_i;
          q_pos      = SW'(count);
          count_next = count + CW'(1);
          swr.en0    = 1'b1;
          swr.val0   = ST_READY;
          addr0      = slot_i;
        end
      end
      OP_EXPIRY: begin
        do_sched = 1'b1;
        a        = st_cur == ST_RUNNING;
      end
      OP_BLOCK: begin
        if (!kind_ok(kind_r)) begin
          err = ERR_KIND;
        end else if (st_cur != ST_RUNNING) begin
          err = ERR_STATUS;
        end else begin
          swr.en0  = 1'b1;
          swr.val0 = kind_s;
          addr0    = cur;
          do_sched = 1'b1;
          idle_eff = (idle_i == cur) ? kind_s : st_idle;
        end
      end
      OP_UNBLOCK: begin
        if (!slot_ok || !is_blocked(st_slot) || full) begin
          err = ERR_STATUS;
        end else begin
          q_cmd.op   = Q_SHIFT_RIGHT;
          q_value    = slot_i;
          count_next = count + CW'(1);
          swr.en0    = 1'b1;
          swr.val0   = ST_READY;
          addr0      = slot_i;
        end
      end
      OP_YIELD: begin
        if (st_cur != ST_RUNNING) begin
          err = ERR_STATUS;
        end else begin
          do_sched = 1'b1;
          a        = 1'b1;
        end
      end
      OP_EXIT: begin
        if (!slot_ok) begin
          err = ERR_STATUS;
        end else if (ns_r && ((a_x && (int'(cnt_after) >= TASK_SLOTS)) ||
                    ((cnt_after == '0) && !a_x &&
                     !(idle_ok && (idle_i != slot_i) && is_blocked(st_idle))))) begin
          err = ERR_STATUS;
        end else begin
          q_cmd.op   = Q_REMOVE;
          q_value    = slot_i;
          count_next = cnt_after;
          swr.en0    = 1'b1;
          swr.val0   = ST_OVER;
          addr0      = slot_i;
          to_sched   = ns_r;
        end
      end
      default: begin
        err = ERR_STATUS;
      end
    endcase

    if (do_sched) begin
      sched_bad = (a && full) ||
                  (empty && !a && !(idle_ok && is_blocked(idle_eff)));
      if (sched_bad) begin
        err = ERR_STATUS;
      end else begin
        next_task = !empty ? entries[0] : (a ? cur : idle_i);
        if (a) begin
          swr.en0  = 1'b1;
          swr.val0 = ST_READY;
          addr0    = cur;
        end
        swr.en1  = 1'b1;
        swr.val1 = ST_RUNNING;
        addr1    = next_task;
        if (!empty) begin
          q_cmd.op   = Q_SHIFT_LEFT;
          q_cmd.ins  = a;
          q_value    = cur;
          q_pos      = SW'(count - CW'(1));
          count_next = count - CW'(1) + CW'(a);
        end
        cur_next = next_task;
        sw       = 1'b1;
      end
    end
  end

  always_comb begin
    if (commit) begin
      q_cmd_g = q_cmd;
    end else begin
      q_cmd_g = '{op: Q_HOLD, ins: 1'b0};
    end
    swr_g   = swr;
    swr_g.en0 = swr.en0 && commit;
    swr_g.en1 = swr.en1 && commit;
  end

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_slot
    rrts_slot_cell #(.IDX(i), .SW(SW)) u_slot (
      .clk    (clk),
      .rst    (rst),
      .wr     (swr_g),
      .addr0  (addr0),
      .addr1  (addr1),
      .status (stat[i])
    );
  end

  assign hits[0] = 1'b0;

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_queue
    logic [SW-1:0] left_in, right_in;
    if (i == 0) begin : g_first
      assign left_in = q_value;
    end else begin : g_inner
      assign left_in = entries[i-1];
    end
    if (i == TASK_SLOTS - 1) begin : g_last
      assign right_in = entries[i];
    end else begin : g_mid
      assign right_in = entries[i+1];
    end
    rrts_queue_cell #(.IDX(i), .SW(SW), .CW(CW)) u_cell (
      .clk     (clk),
      .cmd     (q_cmd_g),
      .value   (q_value),
      .key     (slot_i),
      .pos     (q_pos),
      .count   (count),
      .left    (left_in),
      .right   (right_in),
      .hit_in  (hits[i]),
      .hit_out (hits[i+1]),
      .entry   (entries[i])
    );
  end

  always_comb begin
    seq_next = seq;
    unique case (seq)
      SQ_IDLE:  if (s_tvalid) seq_next = SQ_EXEC;
      SQ_EXEC:  if (go) seq_next = to_sched ? SQ_SCHED : SQ_IDLE;
      SQ_SCHED: if (go) seq_next = SQ_IDLE;
      default:  seq_next = SQ_IDLE;
    endcase
  end

  always_comb begin
    s_tready = seq == SQ_IDLE;
  end

  assign run_o  = commit ? cur_next : cur;
  assign cnt_o  = commit ? count_next : count;
  assign run_x  = XW'(run_o);
  assign prev_x = XW'(cur);
  assign cnt_x  = RW'(cnt_o);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= SQ_IDLE;
      idle_slot <= SLOT_W'(1);
      cur       <= '0;
      count     <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      seq <= seq_next;
      if (cfg_wr_en) begin
        idle_slot <= cfg_wr_data;
      end
      if (commit) begin
        cur   <= cur_next;
        count <= count_next;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_r   <= s_tdata[2:0];
      slot_r <= s_tdata[6:3];
      kind_r <= s_tdata[9:7];
      ns_r   <= s_tdata[10];
    end
    if (load) begin
      m_tdata <= {err, cnt_x[RCOUNT_W-1:0], (sw && commit),
                  prev_x[SLOT_W-1:0], run_x[SLOT_W-1:0]};
    end
  end

endmodule

// File: hw/rtl/rrts_checker.sv
// Port-level checks of the round-robin task scheduler and their bind.
module rrts_checker import rrts_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Result changed or dropped while stalled.");

  a_one_event: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Second transaction accepted while an event is in flight.");

  a_err_no_switch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[15:14] != ERR_OK) |-> !m_tdata[8])
    else $error("Rejected event reports a task switch.");

  a_no_switch_same: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[8] |-> m_tdata[3:0] == m_tdata[7:4])
    else $error("Running task changed without a schedule step.");

  a_err_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:14] == ERR_OK) || (m_tdata[15:14] == ERR_STATUS) ||
                 (m_tdata[15:14] == ERR_KIND))
    else $error("Result carries an unknown error code.");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
